FILE: rtl/ckp_pkg.sv
package ckp_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int ANGLE_WIDTH  = 16;
  localparam int OUT_WIDTH    = 18;

  // Phase accumulator: a full turn is 2^PH_W.
  localparam int PH_W         = 32;
  localparam int CORDIC_STEPS = 20;
  localparam logic signed [PH_W-1:0] CORDIC_X0 = 32'sd652032875;

  // Sine and cosine leave the rotator in Q14, with room for the sign and a small overshoot.
  localparam int TRIG_FRAC = 14;
  localparam int TRIG_W    = TRIG_FRAC + 3;

  // sqrt(3)/2 in Q14.
  localparam int SQ3H_Q14  = 14189;
  localparam int CONST_W   = 15;

  // Forward alpha before scaling: 2A - B - C.
  localparam int AB_W   = SAMPLE_WIDTH + 2;
  // Forward beta before scaling: B - C.
  localparam int BP_W   = SAMPLE_WIDTH + 1;
  // Multiplier operand that holds a sample, the forward alpha or the scaled forward beta.
  localparam int OPX_W  = SAMPLE_WIDTH + CONST_W + 1;
  localparam int PROD_W = OPX_W + TRIG_W;
  // Accumulator for the Q28 sums.
  localparam int ACC_W  = SAMPLE_WIDTH + 36;
  // Inverse beta, narrowed before the sqrt(3)/2 scaling.
  localparam int INV_W  = SAMPLE_WIDTH + TRIG_W + 2;

  localparam logic [PH_W-1:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518
  };

  typedef enum logic {
    REQ_FWD = 1'b0,
    REQ_INV = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    QUAD_0   = 2'd0,
    QUAD_90  = 2'd1,
    QUAD_180 = 2'd2,
    QUAD_270 = 2'd3
  } quad_e;

  // Operands that ride alongside the rotator.
  typedef struct packed {
    req_e                     req;
    logic signed [SAMPLE_WIDTH-1:0] p1;
    logic signed [SAMPLE_WIDTH-1:0] p2;
    logic signed [AB_W-1:0]   al_pre;
    logic signed [OPX_W-1:0]  be_f;
  } side_t;

endpackage

FILE: rtl/ckp_prep.sv
module ckp_prep (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  input  logic                                   req_type_i,
  input  logic signed [ckp_pkg::SAMPLE_WIDTH-1:0] in_first_i,
  input  logic signed [ckp_pkg::SAMPLE_WIDTH-1:0] in_second_i,
  input  logic signed [ckp_pkg::SAMPLE_WIDTH-1:0] in_third_i,
  input  logic        [ckp_pkg::ANGLE_WIDTH-1:0]  angle_i,
  output logic                                   valid_o,
  output ckp_pkg::side_t                         side_o,
  output ckp_pkg::quad_e                         quad_o,
  output logic signed [ckp_pkg::PH_W-1:0]        z_o
);

  localparam int PH_W = ckp_pkg::PH_W;

  logic [PH_W-1:0] phase;
  logic [PH_W-1:0] quad_sum;
  logic [1:0]      quad_bits;
  logic [PH_W-1:0] resid;

  logic signed [ckp_pkg::AB_W-1:0]  al_pre_d;
  logic signed [ckp_pkg::BP_W-1:0]  be_pre_d;
  logic signed [ckp_pkg::OPX_W-1:0] be_f_d;

  logic                                   va_q;
  ckp_pkg::req_e                          req_a_q;
  logic signed [ckp_pkg::SAMPLE_WIDTH-1:0] p1_a_q;
  logic signed [ckp_pkg::SAMPLE_WIDTH-1:0] p2_a_q;
  logic signed [ckp_pkg::AB_W-1:0]        al_a_q;
  logic signed [ckp_pkg::BP_W-1:0]        be_a_q;
  ckp_pkg::quad_e                         quad_a_q;
  logic signed [PH_W-1:0]                 z_a_q;

  logic                   vb_q;
  ckp_pkg::side_t         side_b_q;
  ckp_pkg::quad_e         quad_b_q;
  logic signed [PH_W-1:0] z_b_q;

  // Fold the angle to the nearest quadrant; the rest lies within one eighth of a turn.
  always_comb begin
    phase     = {angle_i, {(PH_W-ckp_pkg::ANGLE_WIDTH){1'b0}}};
    quad_sum  = phase + (PH_W'(1) << (PH_W-3));
    quad_bits = quad_sum[PH_W-1 -: 2];
    resid     = phase - {quad_bits, {(PH_W-2){1'b0}}};
  end

  assign al_pre_d = (ckp_pkg::AB_W'(in_first_i) <<< 1) - ckp_pkg::AB_W'(in_second_i)
                    - ckp_pkg::AB_W'(in_third_i);
  assign be_pre_d = ckp_pkg::BP_W'(in_second_i) - ckp_pkg::BP_W'(in_third_i);
  assign be_f_d   = ckp_pkg::OPX_W'(be_a_q)
                    * ckp_pkg::OPX_W'(ckp_pkg::SQ3H_Q14);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    req_a_q  <= ckp_pkg::req_e'(req_type_i);
    p1_a_q   <= in_first_i;
    p2_a_q   <= in_second_i;
    al_a_q   <= al_pre_d;
    be_a_q   <= be_pre_d;
    quad_a_q <= ckp_pkg::quad_e'(quad_bits);
    z_a_q    <= $signed(resid);

    side_b_q.req    <= req_a_q;
    side_b_q.p1     <= p1_a_q;
    side_b_q.p2     <= p2_a_q;
    side_b_q.al_pre <= al_a_q;
    side_b_q.be_f   <= be_f_d;
    quad_b_q        <= quad_a_q;
    z_b_q           <= z_a_q;
  end

  assign valid_o = vb_q;
  assign side_o  = side_b_q;
  assign quad_o  = quad_b_q;
  assign z_o     = z_b_q;

endmodule

FILE: rtl/ckp_cordic.sv
module ckp_cordic (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  ckp_pkg::side_t                      side_i,
  input  ckp_pkg::quad_e                      quad_i,
  input  logic signed [ckp_pkg::PH_W-1:0]     z_i,
  output logic                                valid_o,
  output ckp_pkg::side_t                      side_o,
  output logic signed [ckp_pkg::TRIG_W-1:0]   cos_o,
  output logic signed [ckp_pkg::TRIG_W-1:0]   sin_o
);

  localparam int PH_W   = ckp_pkg::PH_W;
  localparam int STEPS  = ckp_pkg::CORDIC_STEPS;
  localparam int TRIG_W = ckp_pkg::TRIG_W;
  localparam int RND_SH = PH_W - 2 - ckp_pkg::TRIG_FRAC;

  logic signed [PH_W-1:0] x_in [STEPS];
  logic signed [PH_W-1:0] y_in [STEPS];
  logic signed [PH_W-1:0] z_in [STEPS];
  logic signed [PH_W-1:0] x_nx [STEPS];
  logic signed [PH_W-1:0] y_nx [STEPS];
  logic signed [PH_W-1:0] z_nx [STEPS];

  logic signed [PH_W-1:0] x_q [STEPS];
  logic signed [PH_W-1:0] y_q [STEPS];
  logic signed [PH_W-1:0] z_q [STEPS];
  ckp_pkg::side_t         side_q [STEPS];
  ckp_pkg::quad_e         quad_q [STEPS];
  logic [STEPS-1:0]       v_q;

  logic signed [PH_W:0]     cx;
  logic signed [PH_W:0]     sy;
  logic signed [PH_W:0]     cx_r;
  logic signed [PH_W:0]     sy_r;
  logic                     vo_q;
  ckp_pkg::side_t           side_o_q;
  logic signed [TRIG_W-1:0] cos_q;
  logic signed [TRIG_W-1:0] sin_q;

  // One micro-rotation per stage; each stage turns toward a zero residual angle.
  always_comb begin
    x_in[0] = ckp_pkg::CORDIC_X0;
    y_in[0] = '0;
    z_in[0] = z_i;
    for (int i = 1; i < STEPS; i++) begin
      x_in[i] = x_q[i-1];
      y_in[i] = y_q[i-1];
      z_in[i] = z_q[i-1];
    end
    for (int i = 0; i < STEPS; i++) begin
      if (!z_in[i][PH_W-1]) begin
        x_nx[i] = x_in[i] - (y_in[i] >>> i);
        y_nx[i] = y_in[i] + (x_in[i] >>> i);
        z_nx[i] = z_in[i] - $signed(ckp_pkg::ATAN_TURN[i]);
      end else begin
        x_nx[i] = x_in[i] + (y_in[i] >>> i);
        y_nx[i] = y_in[i] - (x_in[i] >>> i);
        z_nx[i] = z_in[i] + $signed(ckp_pkg::ATAN_TURN[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      vo_q <= 1'b0;
    end else begin
      v_q  <= {v_q[STEPS-2:0], valid_i};
      vo_q <= v_q[STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_i;
    quad_q[0] <= quad_i;
    for (int i = 1; i < STEPS; i++) begin
      side_q[i] <= side_q[i-1];
      quad_q[i] <= quad_q[i-1];
    end
    for (int i = 0; i < STEPS; i++) begin
      x_q[i] <= x_nx[i];
      y_q[i] <= y_nx[i];
      z_q[i] <= z_nx[i];
    end
  end

  // Undo the quadrant fold, then round half up to Q14.
  always_comb begin
    unique case (quad_q[STEPS-1])
      ckp_pkg::QUAD_0: begin
        cx = (PH_W+1)'(x_q[STEPS-1]);
        sy = (PH_W+1)'(y_q[STEPS-1]);
      end
      ckp_pkg::QUAD_90: begin
        cx = -(PH_W+1)'(y_q[STEPS-1]);
        sy = (PH_W+1)'(x_q[STEPS-1]);
      end
      ckp_pkg::QUAD_180: begin
        cx = -(PH_W+1)'(x_q[STEPS-1]);
        sy = -(PH_W+1)'(y_q[STEPS-1]);
      end
      ckp_pkg::QUAD_270: begin
        cx = (PH_W+1)'(y_q[STEPS-1]);
        sy = -(PH_W+1)'(x_q[STEPS-1]);
      end
    endcase
    cx_r = (cx + ((PH_W+1)'(1) <<< (RND_SH-1))) >>> RND_SH;
    sy_r = (sy + ((PH_W+1)'(1) <<< (RND_SH-1))) >>> RND_SH;
  end

  always_ff @(posedge clk_i) begin
    side_o_q <= side_q[STEPS-1];
    cos_q    <= TRIG_W'(cx_r);
    sin_q    <= TRIG_W'(sy_r);
  end

  assign valid_o = vo_q;
  assign side_o  = side_o_q;
  assign cos_o   = cos_q;
  assign sin_o   = sin_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> ##(STEPS+1) valid_o)
    else $error("rotator beat did not come out after the fixed number of stages");

  a_trig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (cos_o <= 17'sd16385) && (cos_o >= -17'sd16385)
                && (sin_o <= 17'sd16385) && (sin_o >= -17'sd16385))
    else $error("sine or cosine beyond unit magnitude");

endmodule

FILE: rtl/ckp_mix.sv
module ckp_mix (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  input  ckp_pkg::side_t                         side_i,
  input  logic signed [ckp_pkg::TRIG_W-1:0]      cos_i,
  input  logic signed [ckp_pkg::TRIG_W-1:0]      sin_i,
  output logic                                   valid_o,
  output logic signed [ckp_pkg::OUT_WIDTH-1:0]   out_first_o,
  output logic signed [ckp_pkg::OUT_WIDTH-1:0]   out_second_o,
  output logic signed [ckp_pkg::OUT_WIDTH-1:0]   out_third_o
);

  localparam int OPX_W  = ckp_pkg::OPX_W;
  localparam int TRIG_W = ckp_pkg::TRIG_W;
  localparam int PROD_W = ckp_pkg::PROD_W;
  localparam int ACC_W  = ckp_pkg::ACC_W;
  localparam int OUT_W  = ckp_pkg::OUT_WIDTH;
  localparam int HSH    = ckp_pkg::TRIG_FRAC - 1;
  localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'((1 <<< (OUT_W-1)) - 1);
  localparam logic signed [ACC_W-1:0] OUT_MIN = ACC_W'(-(1 <<< (OUT_W-1)));
  localparam logic signed [ckp_pkg::CONST_W:0] SQ3H = (ckp_pkg::CONST_W+1)'(ckp_pkg::SQ3H_Q14);

  function automatic logic signed [OUT_W-1:0] round_sat(
    input logic signed [ACC_W-1:0] v,
    input logic                    short_sh
  );
    logic signed [ACC_W-1:0] r;
    logic signed [ACC_W-1:0] t;
    if (short_sh) begin
      r = v + (ACC_W'(1) <<< (ckp_pkg::TRIG_FRAC-1));
      t = r >>> ckp_pkg::TRIG_FRAC;
    end else begin
      r = v + (ACC_W'(1) <<< (2*ckp_pkg::TRIG_FRAC-1));
      t = r >>> (2*ckp_pkg::TRIG_FRAC);
    end
    if (t > OUT_MAX) begin
      t = OUT_MAX;
    end else if (t < OUT_MIN) begin
      t = OUT_MIN;
    end
    return OUT_W'(t);
  endfunction

  logic                     fwd;
  logic signed [OPX_W-1:0]  opa [4];
  logic signed [TRIG_W-1:0] opb [4];
  logic signed [PROD_W-1:0] p_d [4];

  logic [4:0]               v_q;
  ckp_pkg::req_e            req1_q, req2_q, req3_q, req4_q, req5_q;
  logic signed [PROD_W-1:0] p_q [4];

  logic signed [ACC_W-1:0]  s0_d, s1_d, s0_q, s1_q;
  logic signed [ACC_W-1:0]  a3_d, h3_d, m3_d, a3_q, h3_q, m3_q;
  logic signed [ACC_W-1:0]  r0_d, r1_d, r2_d, r0_q, r1_q, r2_q;

  logic signed [OUT_W-1:0]  o0_d, o1_d, o2_d, o0_q, o1_q, o2_q;

  // Forward uses the precomputed alpha/beta; inverse rotates d/q directly.
  always_comb begin
    fwd    = (side_i.req == ckp_pkg::REQ_FWD);
    opa[0] = fwd ? OPX_W'($signed(side_i.al_pre)) : OPX_W'($signed(side_i.p1));
    opa[1] = fwd ? $signed(side_i.be_f)           : OPX_W'($signed(side_i.p2));
    opa[2] = fwd ? $signed(side_i.be_f)           : OPX_W'($signed(side_i.p1));
    opa[3] = fwd ? OPX_W'($signed(side_i.al_pre)) : OPX_W'($signed(side_i.p2));
    opb[0] = cos_i;
    opb[1] = sin_i;
    opb[2] = fwd ? cos_i : sin_i;
    opb[3] = fwd ? sin_i : cos_i;
    for (int k = 0; k < 4; k++) begin
      p_d[k] = opa[k] * opb[k];
    end
  end

  always_comb begin
    if (req1_q == ckp_pkg::REQ_FWD) begin
      s0_d = (ACC_W'(p_q[0]) <<< HSH) + ACC_W'(p_q[1]);
      s1_d = ACC_W'(p_q[2]) - (ACC_W'(p_q[3]) <<< HSH);
    end else begin
      s0_d = ACC_W'(p_q[0]) - ACC_W'(p_q[1]);
      s1_d = ACC_W'(p_q[2]) + ACC_W'(p_q[3]);
    end
  end

  // Inverse: the half-alpha term and beta scaled by sqrt(3)/2; forward passes the second sum through.
  always_comb begin
    a3_d = s0_q;
    if (req2_q == ckp_pkg::REQ_FWD) begin
      h3_d = s1_q;
      m3_d = '0;
    end else begin
      h3_d = -(s0_q <<< HSH);
      m3_d = ckp_pkg::INV_W'(s1_q) * SQ3H;
    end
  end

  always_comb begin
    r0_d = a3_q;
    if (req3_q == ckp_pkg::REQ_FWD) begin
      r1_d = h3_q;
      r2_d = '0;
    end else begin
      r1_d = h3_q + m3_q;
      r2_d = h3_q - m3_q;
    end
  end

  always_comb begin
    if (req4_q == ckp_pkg::REQ_FWD) begin
      o0_d = round_sat(r0_q, 1'b0);
      o1_d = round_sat(r1_q, 1'b0);
      o2_d = '0;
    end else begin
      o0_d = round_sat(r0_q, 1'b1);
      o1_d = round_sat(r1_q, 1'b0);
      o2_d = round_sat(r2_q, 1'b0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    req1_q <= side_i.req;
    req2_q <= req1_q;
    req3_q <= req2_q;
    req4_q <= req3_q;
    req5_q <= req4_q;
    for (int k = 0; k < 4; k++) begin
      p_q[k] <= p_d[k];
    end
    s0_q <= s0_d;
    s1_q <= s1_d;
    a3_q <= a3_d;
    h3_q <= h3_d;
    m3_q <= m3_d;
    r0_q <= r0_d;
    r1_q <= r1_d;
    r2_q <= r2_d;
    o0_q <= o0_d;
    o1_q <= o1_d;
    o2_q <= o2_d;
  end

  assign valid_o      = v_q[4];
  assign out_first_o  = o0_q;
  assign out_second_o = o1_q;
  assign out_third_o  = o2_q;

  a_mix_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> ##5 valid_o)
    else $error("combine stages lost or delayed a beat");

  a_fwd_third: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (req5_q == ckp_pkg::REQ_FWD)) |-> (out_third_o == '0))
    else $error("forward beat carries a nonzero third output");

endmodule

FILE: rtl/clarke_park_transform.sv
// A request accepted at one clock edge shows its result, with done_o high, once it has
// passed the 2 prep, 20 rotator, 1 trig and 5 combine stages.
// Throughput: one request per cycle; busy stays low, since the receiver cannot stall.
// Every stage is registered, so the 20-stage rotator sets the depth but not the rate.
// Reset (rst_ni low, asynchronous) clears every stage's valid bit; beats in flight are dropped.
module clarke_park_transform (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   req_type_i,
  input  logic signed [ckp_pkg::SAMPLE_WIDTH-1:0] in_first_i,
  input  logic signed [ckp_pkg::SAMPLE_WIDTH-1:0] in_second_i,
  input  logic signed [ckp_pkg::SAMPLE_WIDTH-1:0] in_third_i,
  input  logic        [ckp_pkg::ANGLE_WIDTH-1:0]  angle_i,
  output logic                                   done_o,
  output logic signed [ckp_pkg::OUT_WIDTH-1:0]    out_first_o,
  output logic signed [ckp_pkg::OUT_WIDTH-1:0]    out_second_o,
  output logic signed [ckp_pkg::OUT_WIDTH-1:0]    out_third_o
);

  logic                                 accept;
  logic                                 prep_valid;
  ckp_pkg::side_t                       prep_side;
  ckp_pkg::quad_e                       prep_quad;
  logic signed [ckp_pkg::PH_W-1:0]      prep_z;
  logic                                 trig_valid;
  ckp_pkg::side_t                       trig_side;
  logic signed [ckp_pkg::TRIG_W-1:0]    trig_cos;
  logic signed [ckp_pkg::TRIG_W-1:0]    trig_sin;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  ckp_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (accept),
    .req_type_i  (req_type_i),
    .in_first_i  (in_first_i),
    .in_second_i (in_second_i),
    .in_third_i  (in_third_i),
    .angle_i     (angle_i),
    .valid_o     (prep_valid),
    .side_o      (prep_side),
    .quad_o      (prep_quad),
    .z_o         (prep_z)
  );

  ckp_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_valid),
    .side_i  (prep_side),
    .quad_i  (prep_quad),
    .z_i     (prep_z),
    .valid_o (trig_valid),
    .side_o  (trig_side),
    .cos_o   (trig_cos),
    .sin_o   (trig_sin)
  );

  ckp_mix u_mix (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (trig_valid),
    .side_i       (trig_side),
    .cos_i        (trig_cos),
    .sin_i        (trig_sin),
    .valid_o      (done_o),
    .out_first_o  (out_first_o),
    .out_second_o (out_second_o),
    .out_third_o  (out_third_o)
  );

  // done_o rises once the accepted beat has passed the prep, rotator, trig and combine registers.
  a_end_to_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##28 done_o)
    else $error("accepted beat did not produce a result at the fixed latency");

endmodule
